[rtl/core/msel_pkg.sv]
// Package for the maintenance op selector: shared types, state encodings,
// reason codes and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package msel_pkg;

  localparam int unsigned BYTES_W   = 48;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned MIB_SHIFT = 20;  // 1024 * 1024
  localparam int unsigned LIMB_W    = 24;  // operand width of the shared multiplier
  localparam int unsigned ACC_W     = 82;  // holds 33b magnitude times 48b power plus bias

  localparam logic [BYTES_W-1:0] MAX48   = 48'hFFFF_FFFF_FFFF;
  localparam logic [BYTES_W-1:0] SMAX48  = 48'h7FFF_FFFF_FFFF;
  localparam logic [BYTES_W-1:0] SMIN48  = 48'h8000_0000_0000;
  localparam logic [BYTES_W-1:0] ONE_Q16 = 48'd65536;
  localparam logic [ACC_W-1:0]   ROUND_BIAS = 82'd32768;

  localparam logic FUNC_CAND   = 1'b0;
  localparam logic FUNC_DECIDE = 1'b1;

  typedef enum logic [2:0] {
    WHY_NONE   = 3'd0,
    WHY_LOWIO  = 3'd1,
    WHY_MEM    = 3'd2,
    WHY_REPLAY = 3'd3,
    WHY_GC     = 3'd4,
    WHY_PERF   = 3'd5
  } why_e;

  typedef enum logic [2:0] {
    CFG_REPLAY   = 3'd0,
    CFG_GC_MIN   = 3'd1,
    CFG_GC_PROB  = 3'd2,
    CFG_MULT     = 3'd3,
    CFG_INV_MULT = 3'd4,
    CFG_SPAN     = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCORE
  } top_state_e;

  typedef enum logic [3:0] {
    SC_IDLE,
    SC_POW_LO,
    SC_POW_HI,
    SC_POW_RND,
    SC_MUL_LL,
    SC_MUL_LH,
    SC_MUL_HL,
    SC_MUL_HH,
    SC_FIN,
    SC_DONE
  } sc_state_e;

  typedef enum logic [1:0] {
    SH_0,
    SH_24,
    SH_48
  } mac_sh_e;

  typedef struct packed {
    logic                en;
    logic                clear;
    mac_sh_e             sh;
    logic [LIMB_W-1:0]   a;
    logic [LIMB_W-1:0]   b;
  } mac_ctl_t;

  typedef struct packed {
    logic               start;
    logic               gain_zero;
    logic signed [32:0] sum;
    logic signed [7:0]  prio;
  } score_req_t;

  typedef struct packed {
    logic                done;
    logic [BYTES_W-1:0]  score;
  } score_rsp_t;

endpackage

[rtl/core/maintenance_op_selector.sv]
// Maintenance op selector: running bests and decide cascade.
// Instantiates msel_score (which holds the shared msel_mac); depends on msel_pkg.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries candidates (func 0) and
//    decide commands (func 1). Output channel (out_valid_o/out_ready_i) gives
//    one found/chosen_id/why transaction per decide, none per candidate.
//  - Candidate: log, RAM and data bests update on acceptance of an eligible
//    candidate; ineligible candidates are ignored. The perf score runs on the
//    shared 24x24 multiply-accumulate unit: two partial products and a round
//    per priority level, then 4 partial products, a finish and a done state.
//    When the gain or the clamped priority is zero, the score goes straight
//    to the done state.
//  - Decide: evaluated in the accept cycle, result registered, visible the
//    next cycle; bests cleared at the same edge.
//  - in_ready_o is low while a score is running and while a result waits
//    and out_ready_i is low, so a stalled receiver holds off all input.
//  - Reset clears all bests and loads the register defaults; no clearing pass.
//  - cfg_we_i writes register cfg_idx_i at once; unknown indexes are ignored.
`timescale 1ns / 1ps

module maintenance_op_selector (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [27:0]        cfg_wdata_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [7:0]         op_id_i,
  input  logic               eligible_i,
  input  logic               low_io_i,
  input  logic [47:0]        log_bytes_i,
  input  logic [47:0]        ram_bytes_i,
  input  logic [47:0]        data_bytes_i,
  input  logic signed [31:0] perf_gain_i,
  input  logic signed [31:0] workload_i,
  input  logic signed [7:0]  priority_req_i,
  input  logic               mem_pressure_i,
  input  logic [15:0]        random_frac_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [7:0]         chosen_id_o,
  output logic [2:0]         why_o
);
  import msel_pkg::*;

  // configuration registers
  logic [27:0] replay_q, gc_min_q;
  logic [16:0] gc_prob_q;
  logic [23:0] mult_q, inv_mult_q;
  logic [3:0]  span_q;

  // running bests
  logic [BYTES_W-1:0] lowio_bytes_q, logs_bytes_q, logs_ram_q, data_bytes_q, perf_best_q;
  logic [ID_W-1:0]    lowio_id_q, logs_id_q, data_id_q, perf_id_q, cur_id_q;
  logic               perf_seen_q;

  top_state_e state_d, state_q;

  logic out_valid_q, found_q;
  logic [ID_W-1:0] chosen_q;
  why_e why_q, why_d;
  logic [ID_W-1:0] pick_d;

  logic in_acc, cand_acc, dec_acc;
  logic logs_ok, perf_pos, replay_hit, gc_hit, perf_better;

  score_req_t score_req;
  score_rsp_t score_rsp;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign cand_acc   = in_acc && (func_i == FUNC_CAND) && eligible_i;
  assign dec_acc    = in_acc && (func_i == FUNC_DECIDE);

  assign score_req.start     = cand_acc;
  assign score_req.gain_zero = (perf_gain_i == 32'sd0);
  assign score_req.sum       = 33'(perf_gain_i) + 33'(workload_i);
  assign score_req.prio      = priority_req_i;

  msel_score u_score (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (score_req),
    .mult_i     (mult_q),
    .inv_mult_i (inv_mult_q),
    .span_i     (span_q),
    .rsp_o      (score_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (cand_acc) state_d = ST_SCORE;
      ST_SCORE: if (score_rsp.done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // decide cascade
  always_comb begin
    logs_ok    = (|logs_bytes_q) || (|logs_ram_q);
    perf_pos   = perf_seen_q && !perf_best_q[BYTES_W-1] && (|perf_best_q);
    replay_hit = logs_bytes_q[BYTES_W-1:MIB_SHIFT] >= replay_q;
    gc_hit     = (|data_bytes_q) && (data_bytes_q > {gc_min_q, 20'b0}) &&
                 (!perf_pos || ({1'b0, random_frac_i} <= gc_prob_q));
    why_d  = WHY_NONE;
    pick_d = '0;
    if (|lowio_bytes_q) begin
      why_d = WHY_LOWIO;  pick_d = lowio_id_q;
    end else if (mem_pressure_i && logs_ok) begin
      why_d = WHY_MEM;    pick_d = logs_id_q;
    end else if (logs_ok && replay_hit) begin
      why_d = WHY_REPLAY; pick_d = logs_id_q;
    end else if (gc_hit) begin
      why_d = WHY_GC;     pick_d = data_id_q;
    end else if (perf_pos) begin
      why_d = WHY_PERF;   pick_d = perf_id_q;
    end
  end

  assign perf_better = !perf_seen_q || ($signed(score_rsp.score) > $signed(perf_best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (dec_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_acc) begin
      found_q  <= (why_d != WHY_NONE);
      chosen_q <= pick_d;
      why_q    <= why_d;
    end
    if (cand_acc) begin
      cur_id_q <= op_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replay_q   <= 28'd1024;
      gc_min_q   <= 28'd0;
      gc_prob_q  <= 17'd32768;
      mult_q     <= 24'd72090;
      inv_mult_q <= 24'd59578;
      span_q     <= 4'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_REPLAY:   replay_q   <= cfg_wdata_i;
        CFG_GC_MIN:   gc_min_q   <= cfg_wdata_i;
        CFG_GC_PROB:  gc_prob_q  <= cfg_wdata_i[16:0];
        CFG_MULT:     mult_q     <= cfg_wdata_i[23:0];
        CFG_INV_MULT: inv_mult_q <= cfg_wdata_i[23:0];
        CFG_SPAN:     span_q     <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowio_bytes_q <= '0; lowio_id_q <= '0;
      logs_bytes_q  <= '0; logs_ram_q <= '0; logs_id_q <= '0;
      data_bytes_q  <= '0; data_id_q  <= '0;
      perf_best_q   <= '0; perf_id_q  <= '0; perf_seen_q <= 1'b0;
    end else if (dec_acc) begin
      lowio_bytes_q <= '0; lowio_id_q <= '0;
      logs_bytes_q  <= '0; logs_ram_q <= '0; logs_id_q <= '0;
      data_bytes_q  <= '0; data_id_q  <= '0;
      perf_best_q   <= '0; perf_id_q  <= '0; perf_seen_q <= 1'b0;
    end else begin
      if (cand_acc) begin
        if (low_io_i && (log_bytes_i > lowio_bytes_q)) begin
          lowio_bytes_q <= log_bytes_i;
          lowio_id_q    <= op_id_i;
        end
        if ((log_bytes_i > logs_bytes_q) ||
            ((log_bytes_i == logs_bytes_q) && (ram_bytes_i > logs_ram_q))) begin
          logs_bytes_q <= log_bytes_i;
          logs_ram_q   <= ram_bytes_i;
          logs_id_q    <= op_id_i;
        end
        if (data_bytes_i > data_bytes_q) begin
          data_bytes_q <= data_bytes_i;
          data_id_q    <= op_id_i;
        end
      end
      if ((state_q == ST_SCORE) && score_rsp.done && perf_better) begin
        perf_best_q  <= score_rsp.score;
        perf_id_q    <= cur_id_q;
        perf_seen_q  <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign chosen_id_o = chosen_q;
  assign why_o       = why_q;

`ifndef SYNTH
  a_found_matches_why: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (found_o == (why_o != WHY_NONE)))
    else $error("found does not match reason code");

  a_none_has_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (chosen_id_o == '0))
    else $error("nonzero id with no choice");

  a_done_only_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    score_rsp.done |-> (state_q == ST_SCORE))
    else $error("score completed with no candidate pending");

  a_decide_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_acc |=> ((lowio_bytes_q == '0) && (logs_bytes_q == '0) && !perf_seen_q))
    else $error("bests not cleared after decide");
`endif

endmodule

[rtl/core/msel_mac.sv]
// Shared 24x24 multiply-accumulate unit with limb shift and rounding-bias clear.
// Depends on msel_pkg.
`timescale 1ns / 1ps

module msel_mac (
  input  logic                           clk_i,
  input  msel_pkg::mac_ctl_t             ctl_i,
  output logic [msel_pkg::ACC_W-1:0]     acc_o
);
  import msel_pkg::*;

  logic [2*LIMB_W-1:0] prod;
  logic [ACC_W-1:0]    prod_sh;
  logic [ACC_W-1:0]    acc_d, acc_q;

  assign prod = ctl_i.a * ctl_i.b;

  always_comb begin
    case (ctl_i.sh)
      SH_0:    prod_sh = {34'b0, prod};
      SH_24:   prod_sh = {10'b0, prod, 24'b0};
      SH_48:   prod_sh = {prod[33:0], 48'b0};
      default: prod_sh = '0;
    endcase
    acc_d = (ctl_i.clear ? ROUND_BIAS : acc_q) + prod_sh;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

[rtl/core/msel_score.sv]
// Score sequencer: raises the priority multiplier to |p| and scales the
// gain sum, all through one shared msel_mac. Depends on msel_pkg, msel_mac.
`timescale 1ns / 1ps

module msel_score (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  msel_pkg::score_req_t  req_i,
  input  logic [23:0]           mult_i,
  input  logic [23:0]           inv_mult_i,
  input  logic [3:0]            span_i,
  output msel_pkg::score_rsp_t  rsp_o
);
  import msel_pkg::*;

  sc_state_e           state_d, state_q;
  logic [BYTES_W-1:0]  m_d, m_q;
  logic [3:0]          n_d, n_q;
  logic [LIMB_W-1:0]   k_d, k_q;
  logic [32:0]         mag_d, mag_q;
  logic                neg_d, neg_q;
  logic [BYTES_W-1:0]  score_d, score_q;

  mac_ctl_t            mac_ctl;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-17:0]   rounded;

  logic signed [7:0]   span_s;
  logic signed [7:0]   prio_c;
  logic [7:0]          prio_abs;

  msel_mac u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .acc_o (acc)
  );

  assign rounded = acc[ACC_W-1:16];

  always_comb begin
    span_s = signed'({4'b0, span_i});
    if (req_i.prio > span_s) begin
      prio_c = span_s;
    end else if (req_i.prio < -span_s) begin
      prio_c = -span_s;
    end else begin
      prio_c = req_i.prio;
    end
    prio_abs = prio_c[7] ? 8'(-prio_c) : 8'(prio_c);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SC_IDLE: begin
        if (req_i.start) begin
          state_d = (req_i.gain_zero || prio_c == 8'sd0) ? SC_DONE : SC_POW_LO;
        end
      end
      SC_POW_LO:  state_d = SC_POW_HI;
      SC_POW_HI:  state_d = SC_POW_RND;
      SC_POW_RND: state_d = (n_q == 4'd1) ? SC_MUL_LL : SC_POW_LO;
      SC_MUL_LL:  state_d = SC_MUL_LH;
      SC_MUL_LH:  state_d = SC_MUL_HL;
      SC_MUL_HL:  state_d = SC_MUL_HH;
      SC_MUL_HH:  state_d = SC_FIN;
      SC_FIN:     state_d = SC_DONE;
      SC_DONE:    state_d = SC_IDLE;
      default:    state_d = SC_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    m_d     = m_q;
    n_d     = n_q;
    k_d     = k_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    score_d = score_q;
    mac_ctl = '{en: 1'b0, clear: 1'b0, sh: SH_0, a: '0, b: '0};
    unique case (state_q)
      SC_IDLE: begin
        if (req_i.start) begin
          neg_d = req_i.sum[32];
          mag_d = req_i.sum[32] ? (~req_i.sum + 33'd1) : req_i.sum;
          m_d   = ONE_Q16;
          n_d   = prio_abs[3:0];
          k_d   = prio_c[7] ? inv_mult_i : mult_i;
          if (req_i.gain_zero) begin
            score_d = '0;
          end else begin
            score_d = {{(BYTES_W-33){req_i.sum[32]}}, req_i.sum};
          end
        end
      end
      SC_POW_LO: mac_ctl = '{en: 1'b1, clear: 1'b1, sh: SH_0,  a: m_q[23:0],  b: k_q};
      SC_POW_HI: mac_ctl = '{en: 1'b1, clear: 1'b0, sh: SH_24, a: m_q[47:24], b: k_q};
      SC_POW_RND: begin
        m_d = (|rounded[ACC_W-17:BYTES_W]) ? MAX48 : rounded[BYTES_W-1:0];
        n_d = n_q - 4'd1;
      end
      SC_MUL_LL: mac_ctl = '{en: 1'b1, clear: 1'b1, sh: SH_0, a: mag_q[23:0], b: m_q[23:0]};
      SC_MUL_LH: mac_ctl = '{en: 1'b1, clear: 1'b0, sh: SH_24, a: mag_q[23:0], b: m_q[47:24]};
      SC_MUL_HL: begin
        mac_ctl = '{en: 1'b1, clear: 1'b0, sh: SH_24, a: {15'b0, mag_q[32:24]}, b: m_q[23:0]};
      end
      SC_MUL_HH: begin
        mac_ctl = '{en: 1'b1, clear: 1'b0, sh: SH_48, a: {15'b0, mag_q[32:24]}, b: m_q[47:24]};
      end
      SC_FIN: begin
        // |res| >= 2^47 saturates in either direction
        if (neg_q) begin
          score_d = (|rounded[ACC_W-17:BYTES_W-1]) ? SMIN48 : (~rounded[BYTES_W-1:0] + 48'd1);
        end else begin
          score_d = (|rounded[ACC_W-17:BYTES_W-1]) ? SMAX48 : rounded[BYTES_W-1:0];
        end
      end
      SC_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    n_q     <= n_d;
    k_q     <= k_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    score_q <= score_d;
  end

  assign rsp_o.done  = (state_q == SC_DONE);
  assign rsp_o.score = score_q;

endmodule

[tb/maintenance_op_selector_test.sv]
// Self-checking testbench for maintenance_op_selector: drives candidate and decide
// transactions, predicts each decision in-bench, and compares found/chosen_id/why.
// Depends on msel_pkg and the maintenance_op_selector RTL.
`timescale 1ns / 1ps

module maintenance_op_selector_test;
  import msel_pkg::*;

  localparam logic [2:0] CFG_SPARE_LO = 3'd6;  // indexes past the register list
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 64;            // covers the longest score run
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 250;

  typedef struct packed {
    logic        func;
    logic [7:0]  op_id;
    logic        eligible;
    logic        low_io;
    logic [47:0] log_bytes;
    logic [47:0] ram_bytes;
    logic [47:0] data_bytes;
    logic [31:0] perf_gain;
    logic [31:0] workload;
    logic [7:0]  prio;
    logic        mem_pressure;
    logic [15:0] random_frac;
  } sel_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] chosen_id;
    why_e       why;
  } sel_choice_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [27:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  sel_item_t   drv_item = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic        found_o;
  logic [7:0]  chosen_id_o;
  logic [2:0]  why_o;

  // register shadow
  logic [27:0] cfg_replay = 28'd1024;
  logic [27:0] cfg_gc_min = 28'd0;
  logic [16:0] cfg_gc_prob = 17'd32768;
  logic [23:0] cfg_mult = 24'd72090;
  logic [23:0] cfg_inv_mult = 24'd59578;
  logic [3:0]  cfg_span = 4'd5;

  // running bests
  logic [47:0]        top_lowio_log = '0;
  logic [7:0]         top_lowio_id = '0;
  logic [47:0]        top_log_bytes = '0;
  logic [47:0]        top_log_ram = '0;
  logic [7:0]         top_log_id = '0;
  logic [47:0]        top_data_bytes = '0;
  logic [7:0]         top_data_id = '0;
  logic signed [47:0] top_perf_best = '0;
  logic [7:0]         top_perf_id = '0;
  logic               perf_valid = 1'b0;

  sel_item_t   op_q[$];
  sel_choice_t choice_q[$];
  int          mismatches = 0;
  int          tx_gap_max = 6;
  int          rx_gap_max = 6;
  int          tx_wait = 0;
  int          rx_wait = 0;
  int          hold_reqs = 0;
  int          hold_done = 0;
  logic [47:0] last_bytes = '0;

  maintenance_op_selector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .func_i         (drv_item.func),
    .op_id_i        (drv_item.op_id),
    .eligible_i     (drv_item.eligible),
    .low_io_i       (drv_item.low_io),
    .log_bytes_i    (drv_item.log_bytes),
    .ram_bytes_i    (drv_item.ram_bytes),
    .data_bytes_i   (drv_item.data_bytes),
    .perf_gain_i    (drv_item.perf_gain),
    .workload_i     (drv_item.workload),
    .priority_req_i (drv_item.prio),
    .mem_pressure_i (drv_item.mem_pressure),
    .random_frac_i  (drv_item.random_frac),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .found_o        (found_o),
    .chosen_id_o    (chosen_id_o),
    .why_o          (why_o)
  );

  always #1 clk_i = ~clk_i;

  // Adjusted perf score in the integer scale of the gain sum (power in Q16.16), saturated to signed 48 bits.
  function automatic logic signed [47:0] adj_score(logic [31:0] gain, logic [31:0] work,
                                                   logic [7:0] prio_raw);
    longint       s;
    int           p;
    int           span;
    int           n;
    logic [23:0]  k;
    logic [127:0] m;
    logic [127:0] mag;
    logic [127:0] res;
    if (gain == '0) return '0;
    s = longint'($signed(gain)) + longint'($signed(work));
    span = int'(cfg_span);
    p = int'($signed(prio_raw));
    if (p < -span) p = -span;
    if (p > span) p = span;
    if (p == 0) return 48'(s);
    k = (p > 0) ? cfg_mult : cfg_inv_mult;
    n = (p > 0) ? p : -p;
    m = 128'd65536;
    repeat (n) begin
      m = (m * k + 128'd32768) >> 16;
      if (m > MAX48) m = MAX48;
    end
    mag = (s < 0) ? 128'(-s) : 128'(s);
    res = (mag * m + 128'd32768) >> 16;
    if (s < 0) return (res >= (128'd1 << 47)) ? SMIN48 : -res[47:0];
    return (res > SMAX48) ? SMAX48 : res[47:0];
  endfunction

  // Fold one accepted transaction into the bests; a decide queues its choice and clears them.
  function automatic void update_selection(sel_item_t it);
    sel_choice_t        ch;
    logic signed [47:0] sc;
    logic               logs_ok;
    logic               perf_pos;
    logic [47:0]        gc_floor;
    if (it.func == FUNC_CAND) begin
      if (!it.eligible) return;
      if (it.low_io && it.log_bytes > top_lowio_log) begin
        top_lowio_log = it.log_bytes;
        top_lowio_id = it.op_id;
      end
      if (it.log_bytes > top_log_bytes ||
          (it.log_bytes == top_log_bytes && it.ram_bytes > top_log_ram)) begin
        top_log_bytes = it.log_bytes;
        top_log_ram = it.ram_bytes;
        top_log_id = it.op_id;
      end
      if (it.data_bytes > top_data_bytes) begin
        top_data_bytes = it.data_bytes;
        top_data_id = it.op_id;
      end
      sc = adj_score(it.perf_gain, it.workload, it.prio);
      if (!perf_valid || sc > top_perf_best) begin
        top_perf_best = sc;
        top_perf_id = it.op_id;
        perf_valid = 1'b1;
      end
      return;
    end
    logs_ok = (top_log_bytes != '0) || (top_log_ram != '0);
    perf_pos = perf_valid && (top_perf_best > 0);
    gc_floor = 48'(cfg_gc_min) << MIB_SHIFT;
    ch.chosen_id = '0;
    ch.why = WHY_NONE;
    if (top_lowio_log != '0) begin
      ch.chosen_id = top_lowio_id;
      ch.why = WHY_LOWIO;
    end else if (it.mem_pressure && logs_ok) begin
      ch.chosen_id = top_log_id;
      ch.why = WHY_MEM;
    end else if (logs_ok && (top_log_bytes >> MIB_SHIFT) >= cfg_replay) begin
      ch.chosen_id = top_log_id;
      ch.why = WHY_REPLAY;
    end else if (top_data_bytes != '0 && top_data_bytes > gc_floor &&
                 (!perf_pos || it.random_frac <= cfg_gc_prob)) begin
      ch.chosen_id = top_data_id;
      ch.why = WHY_GC;
    end else if (perf_pos) begin
      ch.chosen_id = top_perf_id;
      ch.why = WHY_PERF;
    end
    ch.found = (ch.why != WHY_NONE);
    choice_q.push_back(ch);
    top_lowio_log = '0;
    top_lowio_id = '0;
    top_log_bytes = '0;
    top_log_ram = '0;
    top_log_id = '0;
    top_data_bytes = '0;
    top_data_id = '0;
    top_perf_best = '0;
    top_perf_id = '0;
    perf_valid = 1'b0;
  endfunction

  // Sender: one transaction at a time from op_q, random gap after each.
  always @(posedge clk_i) begin : sender
    logic nxt_valid;
    nxt_valid = in_valid;
    if (rst_n && in_valid && in_ready_o) begin
      update_selection(drv_item);
      nxt_valid = 1'b0;
      tx_wait = $urandom_range(0, tx_gap_max);
    end else if (!in_valid && tx_wait != 0) begin
      tx_wait--;
    end
    if (!nxt_valid && tx_wait == 0 && op_q.size() != 0) begin
      drv_item <= op_q.pop_front();
      nxt_valid = 1'b1;
    end
    in_valid <= nxt_valid;
  end

  // Receiver: compare each result with the oldest expected choice.
  always @(posedge clk_i) begin : receiver
    sel_choice_t want;
    logic        took;
    took = rst_n && out_valid_o && out_ready;
    if (took) begin
      if (choice_q.size() == 0) begin
        $error("result with no decide pending: found %0d id %0d why %0d",
               found_o, chosen_id_o, why_o);
        mismatches++;
      end else begin
        want = choice_q.pop_front();
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          mismatches++;
        end
        if (chosen_id_o !== want.chosen_id) begin
          $error("chosen_id: expected %0d, got %0d", want.chosen_id, chosen_id_o);
          mismatches++;
        end
        if (why_o !== want.why) begin
          $error("why: expected %0d, got %0d", want.why, why_o);
          mismatches++;
        end
      end
    end
    if (hold_done != hold_reqs) begin
      hold_done++;
      rx_wait = LONG_HOLD;
    end else if (took) begin
      rx_wait = $urandom_range(0, rx_gap_max);
    end else if (rx_wait != 0) begin
      rx_wait--;
    end
    out_ready <= (rx_wait == 0);
  end

  function automatic sel_item_t mk_cand(logic [7:0] id, logic lowio, logic [47:0] logb,
                                        logic [47:0] ram, logic [47:0] dat,
                                        logic [31:0] gain, logic [31:0] work,
                                        logic [7:0] prio);
    sel_item_t it;
    it.func = FUNC_CAND;
    it.op_id = id;
    it.eligible = 1'b1;
    it.low_io = lowio;
    it.log_bytes = logb;
    it.ram_bytes = ram;
    it.data_bytes = dat;
    it.perf_gain = gain;
    it.workload = work;
    it.prio = prio;
    it.mem_pressure = 1'($urandom_range(0, 1));
    it.random_frac = 16'($urandom);
    return it;
  endfunction

  function automatic logic [47:0] rand_bytes();
    logic [47:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = MAX48;
      2:       v = last_bytes;  // ties
      default: v = 48'({$urandom, $urandom} >> $urandom_range(0, 47));
    endcase
    last_bytes = v;
    return v;
  endfunction

  function automatic sel_item_t rand_item(logic is_decide);
    sel_item_t it;
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 1)) w = 32'($signed(w) >>> $urandom_range(0, 31));
    it = mk_cand(8'($urandom), $urandom_range(0, 7) == 0, rand_bytes(), rand_bytes(),
                 rand_bytes(), ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom), w,
                 ($urandom_range(0, 3) != 0) ? 8'(int'($urandom_range(0, 32)) - 16)
                                             : 8'($urandom));
    it.eligible = ($urandom_range(0, 9) != 0);
    if (is_decide) begin
      it.func = FUNC_DECIDE;
      it.mem_pressure = ($urandom_range(0, 3) == 0);
    end
    return it;
  endfunction

  function automatic sel_item_t mk_decide(logic mem, logic [15:0] frac);
    sel_item_t it;
    it = rand_item(1'b1);
    it.mem_pressure = mem;
    it.random_frac = frac;
    return it;
  endfunction

  // Wait until the block is idle: nothing queued, offered or outstanding.
  task automatic drain();
    while (op_q.size() != 0 || in_valid || choice_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [27:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_REPLAY:   cfg_replay = data;
      CFG_GC_MIN:   cfg_gc_min = data;
      CFG_GC_PROB:  cfg_gc_prob = data[16:0];
      CFG_MULT:     cfg_mult = data[23:0];
      CFG_INV_MULT: cfg_inv_mult = data[23:0];
      CFG_SPAN:     cfg_span = data[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [27:0] replay, logic [27:0] gc_min, logic [27:0] prob,
                              logic [27:0] mult, logic [27:0] inv, logic [27:0] span);
    cfg_write(CFG_REPLAY, replay);
    cfg_write(CFG_GC_MIN, gc_min);
    cfg_write(CFG_GC_PROB, prob);
    cfg_write(CFG_MULT, mult);
    cfg_write(CFG_INV_MULT, inv);
    cfg_write(CFG_SPAN, span);
    cfg_write(CFG_SPARE_LO, 28'($urandom));
    cfg_write(CFG_SPARE_HI, 28'($urandom));
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Mostly candidate groups closed by a decide; some stray transactions.
  task automatic run_phase(int tx_max, int rx_max, logic long_hold);
    int cnt;
    int n;
    tx_gap_max = tx_max;
    rx_gap_max = rx_max;
    if (long_hold) hold_reqs++;
    cnt = 0;
    while (cnt < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        op_q.push_back(rand_item(1'($urandom_range(0, 1))));
        cnt++;
      end else begin
        n = $urandom_range(0, 6);
        repeat (n) op_q.push_back(rand_item(1'b0));
        op_q.push_back(rand_item(1'b1));
        cnt += n + 1;
      end
    end
    drain();
  endtask

  initial begin : stimulus
    sel_item_t it;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed part, reset register values
    op_q.push_back(mk_decide(1'b0, 16'd0));  // nothing to choose
    op_q.push_back(mk_cand(8'hFF, 1'b1, MAX48, MAX48, MAX48, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           8'h7F));
    op_q.push_back(mk_decide(1'b1, 16'hFFFF));
    it = mk_cand(8'h11, 1'b1, MAX48, MAX48, MAX48, 32'h7FFF_FFFF, 32'd0, 8'd1);
    it.eligible = 1'b0;  // ignored
    op_q.push_back(it);
    op_q.push_back(mk_decide(1'b0, 16'd0));
    op_q.push_back(mk_cand(8'd1, 1'b0, 48'd0, 48'd5, 48'd0, 32'd0, 32'd7, 8'd2));
    op_q.push_back(mk_decide(1'b1, 16'd0));  // memory pressure on RAM only
    op_q.push_back(mk_cand(8'd2, 1'b0, 48'd1024 << 20, 48'd0, 48'd0, 32'hFFFF_FFFF, 32'd0,
                           8'd0));
    op_q.push_back(mk_decide(1'b0, 16'd0));  // exactly at replay target
    op_q.push_back(mk_cand(8'd3, 1'b0, (48'd1024 << 20) - 1, 48'd7, 48'd100, 32'h0001_0000,
                           32'd0, 8'd3));
    op_q.push_back(mk_cand(8'd4, 1'b0, (48'd1024 << 20) - 1, 48'd9, 48'd100, 32'h8000_0000,
                           32'h8000_0000, 8'h80));
    op_q.push_back(mk_decide(1'b0, 16'h8000));  // GC at probability edge
    op_q.push_back(mk_cand(8'd5, 1'b0, 48'd0, 48'd0, 48'd50, 32'h0001_0000, 32'd0, 8'd0));
    op_q.push_back(mk_decide(1'b0, 16'h8001));  // perf wins just past it
    op_q.push_back(mk_cand(8'd6, 1'b0, 48'd0, 48'd0, 48'd0, 32'h8000_0000, 32'h8000_0000,
                           8'h80));
    op_q.push_back(mk_decide(1'b0, 16'd0));  // negative perf best is not chosen
    op_q.push_back(mk_cand(8'd0, 1'b1, 48'd0, 48'd0, 48'd0, 32'd0, 32'hFFFF_FFFF, 8'h7F));
    op_q.push_back(mk_decide(1'b1, 16'd0));
    drain();

    apply_config(28'd0, 28'd0, 28'd0, 28'hFFF_FFFF, 28'd0, 28'd15);
    run_phase(6, 6, 1'b0);
    apply_config(28'hFFF_FFFF, 28'hFFF_FFFF, 28'd65536, 28'd0, 28'hFF_FFFF, 28'd1);
    run_phase(6, 6, 1'b0);
    apply_config(28'($urandom_range(0, 2048)), 28'($urandom_range(0, 16)), 28'($urandom),
                 28'($urandom), 28'($urandom), 28'($urandom));
    run_phase(6, 6, 1'b1);
    apply_config(28'($urandom_range(0, 2048)), 28'($urandom_range(0, 16)),
                 28'($urandom_range(0, 65536)), 28'd72090, 28'd59578, 28'd0);
    run_phase(0, 0, 1'b0);
    apply_config(28'($urandom_range(0, 64)), 28'($urandom_range(0, 4)),
                 28'($urandom_range(0, 65536)), 28'($urandom_range(60000, 90000)),
                 28'($urandom_range(40000, 70000)), 28'd5);
    run_phase(6, 6, 1'b0);
    apply_config(28'($urandom), 28'($urandom_range(0, 1)), 28'($urandom), 28'($urandom),
                 28'($urandom), 28'($urandom));
    run_phase(3, 6, 1'b0);

    if (mismatches == 0 && choice_q.size() == 0) begin
      $display("maintenance_op_selector test passed");
    end else begin
      $display("maintenance_op_selector test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("maintenance_op_selector test failed");
    $finish;
  end

endmodule
